// ----- design/rau_pkg.sv -----
// Package: shared types, constants and codes of the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  localparam int DefWidth = 32;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_DENZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
    logic               a_less;
    logic               a_equal;
  } rau_out_t;

  // Classified work handed from the front end to the back end.
  typedef struct packed {
    logic               err;
    logic [1:0]         status;
    logic [1:0]         action;
    logic signed [32:0] an;
    logic signed [32:0] ad;
    logic signed [32:0] bn;
    logic signed [32:0] bd;
    logic               a_less;
    logic               a_equal;
  } rau_job_t;

endpackage
`default_nettype wire

// ----- design/rational_arithmetic_unit_top.sv -----
// Top level of the rational arithmetic unit.
//
// Input channel in_valid/in_stall/in_data carries an action and two
// rationals; output channel out_valid/out_stall/out_data returns the reduced
// result, a status code and the less-than and equality flags. A transaction
// moves when valid is high and stall is low.
// The front end registers an item and classifies it once its job register
// is free; a two-entry queue hands it to the back end. The back end forms
// the cross products, runs a binary gcd (one step a cycle) on magnitudes of
// up to 63 bits and two 64-step restoring divisions. It takes a new item
// only after it has finished the last; sustained rate is one item per
// back-end pass, set by the gcd loop and the shared divider. Error items
// skip the arithmetic and go from idle straight to the output state.
// Reset clears all control state; no item is in flight afterwards.
// When the receiver stalls, the result holds in the output register, the
// back end waits, the queue fills and in_stall then stays high.
`default_nettype none
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int WIDTH = DefWidth
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire rau_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output rau_out_t     out_data
);

  logic     f_v, f_s, q_v, q_s;
  rau_job_t f_j, q_j;

  rau_front #(.WIDTH(WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid(f_v), .job_stall(f_s), .job(f_j)
  );

  rau_queue u_queue (
    .clk, .rst_n, .wr_valid(f_v), .wr_stall(f_s), .wr_data(f_j),
    .rd_valid(q_v), .rd_stall(q_s), .rd_data(q_j)
  );

  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk, .rst_n, .job_valid(q_v), .job_stall(q_s), .job(q_j),
    .out_valid, .out_stall, .out_data
  );

endmodule
`default_nettype wire

// ----- design/rau_front.sv -----
// Front end: accept items, sign- or zero-extend operands, compute flags and error class.
`default_nettype none
module rau_front
  import rau_pkg::*;
#(
  parameter int WIDTH = DefWidth
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire rau_in_t  in_data,
  output logic          job_valid,
  input  wire logic     job_stall,
  output rau_job_t      job
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_CMP  = 2'b10
  } fstate_t;

  fstate_t            state_r, state_nxt;
  logic [1:0]         act_r;
  logic signed [32:0] an_r, ad_r, bn_r, bd_r;
  logic signed [65:0] p1_r, p2_r;
  logic               out_v_r, out_v_nxt;
  rau_job_t           job_r, job_nxt;

  // Field extraction to WIDTH bits (WIDTH-1 for denominators), then sign/zero extension.
  logic signed [32:0] an_w, ad_w, bn_w, bd_w;
  always_comb begin
    an_w = 33'(signed'(in_data.a_num[WIDTH-1:0]));
    bn_w = 33'(signed'(in_data.b_num[WIDTH-1:0]));
    ad_w = 33'(in_data.a_den[WIDTH-2:0]);
    bd_w = 33'(in_data.b_den[WIDTH-2:0]);
  end

  assign in_stall  = (state_r != F_IDLE);
  assign job_valid = out_v_r;
  assign job       = job_r;

  // Build the job once the cross products are registered.
  always_comb begin
    state_nxt = state_r;
    out_v_nxt = out_v_r;
    job_nxt   = job_r;
    if (out_v_r && !job_stall) out_v_nxt = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (in_valid) state_nxt = F_CMP;
      end
      F_CMP: begin
        if (!out_v_nxt) begin
          out_v_nxt       = 1'b1;
          state_nxt       = F_IDLE;
          job_nxt.action  = act_r;
          job_nxt.an      = an_r;
          job_nxt.ad      = ad_r;
          job_nxt.bn      = bn_r;
          job_nxt.bd      = bd_r;
          job_nxt.a_less  = p1_r < p2_r;
          job_nxt.a_equal = (an_r == bn_r) && (ad_r == bd_r);
          if (ad_r == '0 || bd_r == '0) begin
            job_nxt.err = 1'b1; job_nxt.status = ST_DENZ;
          end else if (act_r == ACT_DIV && bn_r == '0) begin
            job_nxt.err = 1'b1; job_nxt.status = ST_DIVZ;
          end else begin
            job_nxt.err = 1'b0; job_nxt.status = ST_OK;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
    job_r <= job_nxt;
    if (state_r == F_IDLE && in_valid) begin
      act_r <= in_data.action;
      an_r  <= an_w;
      ad_r  <= ad_w;
      bn_r  <= bn_w;
      bd_r  <= bd_w;
      p1_r  <= an_w * bd_w;
      p2_r  <= ad_w * bn_w;
    end
  end

  // A job is never dropped while the back end stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job_stall |=> job_valid)
    else $error("job lost under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job_stall |=> $stable(job))
    else $error("job changed under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == F_CMP |-> in_stall)
    else $error("input taken while busy");

endmodule
`default_nettype wire

// ----- design/rau_queue.sv -----
// Two-entry queue between front end and back end.
`default_nettype none
module rau_queue
  import rau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_valid,
  output logic          wr_stall,
  input  wire rau_job_t wr_data,
  output logic          rd_valid,
  input  wire logic     rd_stall,
  output rau_job_t      rd_data
);

  rau_job_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  // Advance pointers and the fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count did not advance");
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid && rd_stall |=> rd_valid)
    else $error("queue lost an entry");

endmodule
`default_nettype wire

// ----- design/rau_back.sv -----
// Back end: form the result, reduce by a binary gcd, divide, range check.
`default_nettype none
module rau_back
  import rau_pkg::*;
#(
  parameter int WIDTH = DefWidth
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     job_valid,
  output logic          job_stall,
  input  wire rau_job_t job,
  output logic          out_valid,
  input  wire logic     out_stall,
  output rau_out_t      out_data
);

  typedef enum logic [7:0] {
    B_IDLE = 8'b0000_0001,
    B_MUL  = 8'b0000_0010,
    B_SUM  = 8'b0000_0100,
    B_GCD  = 8'b0000_1000,
    B_DIVN = 8'b0001_0000,
    B_DIVD = 8'b0010_0000,
    B_CHK  = 8'b0100_0000,
    B_OUT  = 8'b1000_0000
  } bstate_t;

  localparam logic [63:0] Lim = 64'(1) << (WIDTH - 1);

  bstate_t            state_r;
  rau_job_t           j_r;
  logic signed [65:0] p1_r, p2_r, p3_r;
  logic               neg_r;
  logic [63:0]        mn_r, md_r, u_r, v_r;
  logic [5:0]         k_r;
  logic [63:0]        g_r;
  // Restoring divider.
  logic [63:0]        dq_r, drem_r;
  logic [5:0]         dcnt_r;
  logic [64:0]        dtrial;
  rau_out_t           out_r;
  logic               out_v_r;
  logic               out_free;

  assign job_stall = (state_r != B_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign out_free  = !out_v_r || !out_stall;

  assign dtrial = {drem_r, dq_r[63]} - {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_v_r <= 1'b0;
    end else begin
      // Load a new result or drop the one just taken.
      if (state_r == B_OUT && out_free) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
      case (state_r)
        // Latch the job; errors skip the math.
        B_IDLE: begin
          if (job_valid) begin
            j_r     <= job;
            state_r <= job.err ? B_OUT : B_MUL;
          end
        end
        // Form cross products: three for add and subtract, two for multiply and divide.
        B_MUL: begin
          case (j_r.action)
            ACT_MUL: begin
              p1_r <= j_r.an * j_r.bn; p2_r <= '0; p3_r <= j_r.ad * j_r.bd;
            end
            ACT_DIV: begin
              p1_r <= j_r.an * j_r.bd; p2_r <= '0; p3_r <= j_r.ad * j_r.bn;
            end
            default: begin
              p1_r <= j_r.an * j_r.bd; p2_r <= j_r.ad * j_r.bn;
              p3_r <= j_r.ad * j_r.bd;
            end
          endcase
          state_r <= B_SUM;
        end
        // Combine and take magnitudes.
        B_SUM: begin
          logic signed [65:0] n;
          n = (j_r.action == ACT_ADD) ? p1_r + p2_r :
              (j_r.action == ACT_SUB) ? p1_r - p2_r : p1_r;
          neg_r   <= (n < 0) != (p3_r < 0);
          mn_r    <= 64'(n < 0 ? -n : n);
          md_r    <= 64'(p3_r < 0 ? -p3_r : p3_r);
          u_r     <= 64'(n < 0 ? -n : n);
          v_r     <= 64'(p3_r < 0 ? -p3_r : p3_r);
          k_r     <= '0;
          state_r <= B_GCD;
        end
        // Binary gcd, one step a cycle.
        B_GCD: begin
          if (u_r == '0) begin
            g_r     <= v_r << k_r;
            state_r <= B_DIVN;
            dq_r    <= mn_r; drem_r <= '0; dcnt_r <= '0;
          end else if (!u_r[0] && !v_r[0]) begin
            u_r <= u_r >> 1; v_r <= v_r >> 1; k_r <= k_r + 6'd1;
          end else if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (u_r >= v_r) begin
            u_r <= (u_r - v_r) >> 1;
          end else begin
            v_r <= (v_r - u_r) >> 1;
          end
        end
        // Divide numerator, then denominator, by the gcd.
        B_DIVN, B_DIVD: begin
          if (dcnt_r == 6'd63) begin
            dcnt_r <= '0;
            drem_r <= '0;
            if (state_r == B_DIVN) begin
              mn_r    <= {dq_r[62:0], !dtrial[64]};
              dq_r    <= md_r;
              state_r <= B_DIVD;
            end else begin
              md_r    <= {dq_r[62:0], !dtrial[64]};
              state_r <= B_CHK;
            end
          end else begin
            dcnt_r <= dcnt_r + 6'd1;
            if (!dtrial[64]) begin
              drem_r <= dtrial[63:0];
              dq_r   <= {dq_r[62:0], 1'b1};
            end else begin
              drem_r <= {drem_r[62:0], dq_r[63]};
              dq_r   <= {dq_r[62:0], 1'b0};
            end
          end
        end
        // Range check and sign.
        B_CHK: begin
          logic ng;
          ng = neg_r && (mn_r != '0);
          if (md_r > Lim - 64'd1 || (ng ? mn_r > Lim : mn_r > Lim - 64'd1)) begin
            j_r.status <= ST_OVF;
            j_r.err    <= 1'b1;
          end else begin
            u_r <= ng ? -mn_r : mn_r;
          end
          state_r <= B_OUT;
        end
        // Present the result when the output register is free.
        B_OUT: begin
          if (out_free) begin
            out_r.status     <= j_r.status;
            out_r.a_less     <= j_r.a_less;
            out_r.a_equal    <= j_r.a_equal;
            out_r.res_num    <= j_r.err ? '0 : u_r[31:0];
            out_r.res_den    <= j_r.err ? '0 : md_r[30:0];
            state_r          <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_IDLE && job_valid && !job.err |=> state_r == B_MUL)
    else $error("job not started");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_DIVD |-> g_r != '0)
    else $error("zero gcd");

endmodule
`default_nettype wire

// ----- tb/tb_rational_arithmetic_unit_top.sv -----
// Testbench for the rational arithmetic unit: directed and random operands checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_rational_arithmetic_unit_top;
  import rau_pkg::*;

  localparam int LimitCycles = 2000000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rau_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rau_out_t out_data;
  logic     in_accepted;

  rau_in_t  pending_ops[$];
  rau_out_t expected_results[$];
  int       fail_count;
  int       result_count;
  int       cycle_count;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       status_seen[4];

  rational_arithmetic_unit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Compute the reduced rational result and flags for one operation.
  function automatic rau_out_t rational_result(rau_in_t op);
    rau_out_t r;
    logic signed [63:0] an, ad, bn, bd, n, d;
    logic [63:0] mn, md, g;
    logic neg;
    an = op.a_num;
    bn = op.b_num;
    ad = {33'd0, op.a_den};
    bd = {33'd0, op.b_den};
    r = '0;
    r.a_less = (an * bd) < (ad * bn);
    r.a_equal = (an == bn) && (ad == bd);
    if (ad == 0 || bd == 0) begin
      r.status = ST_DENZ;
    end else if (op.action == ACT_DIV && bn == 0) begin
      r.status = ST_DIVZ;
    end else begin
      case (op.action)
        ACT_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
        ACT_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
        ACT_MUL: begin n = an * bn; d = ad * bd; end
        default: begin n = an * bd; d = ad * bn; end
      endcase
      neg = (n < 0) != (d < 0);
      mn = n < 0 ? -n : n;
      md = d < 0 ? -d : d;
      g = gcd64(mn, md);
      mn = mn / g;
      md = md / g;
      if (mn == 0) neg = 1'b0;
      if (md > 64'h7FFF_FFFF || (neg ? mn > 64'h8000_0000 : mn > 64'h7FFF_FFFF)) begin
        r.status = ST_OVF;
      end else begin
        r.status = ST_OK;
        r.res_num = neg ? -mn[31:0] : mn[31:0];
        r.res_den = md[30:0];
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 40)) - 20);
      3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 6))
      0: return 31'h7FFF_FFFF;
      1: return 31'd1;
      2: return 31'($urandom_range(1, 30));
      3: return 31'($urandom_range(1, 3000));
      4: return ($urandom_range(0, 40) == 0) ? 31'd0 : 31'($urandom_range(1, 7));
      default: return 31'($urandom) | 31'd1;
    endcase
  endfunction

  task automatic add_op(logic [1:0] act, logic [31:0] an, logic [30:0] ad,
                        logic [31:0] bn, logic [30:0] bd);
    rau_in_t op;
    op.action = act;
    op.a_num = an;
    op.a_den = ad;
    op.b_num = bn;
    op.b_den = bd;
    pending_ops.push_back(op);
  endtask

  // Drive transactions from the pending queue; hold payload until accepted; randomize out_stall.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_ops.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Predict on input acceptance, check on output acceptance.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_accepted <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      expected_results.push_back(rational_result(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        fail_count = fail_count + 1;
      end else begin
        rau_out_t e;
        e = expected_results.pop_front();
        result_count = result_count + 1;
        status_seen[e.status] = status_seen[e.status] + 1;
        if (out_data.res_num !== e.res_num) begin
          $error("res_num expected %0d got %0d", e.res_num, out_data.res_num);
          fail_count = fail_count + 1;
        end
        if (out_data.res_den !== e.res_den) begin
          $error("res_den expected %0d got %0d", e.res_den, out_data.res_den);
          fail_count = fail_count + 1;
        end
        if (out_data.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_data.status);
          fail_count = fail_count + 1;
        end
        if (out_data.a_less !== e.a_less) begin
          $error("a_less expected %0d got %0d", e.a_less, out_data.a_less);
          fail_count = fail_count + 1;
        end
        if (out_data.a_equal !== e.a_equal) begin
          $error("a_equal expected %0d got %0d", e.a_equal, out_data.a_equal);
          fail_count = fail_count + 1;
        end
      end
    end
    if (cycle_count > LimitCycles) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("FAIL rational_arithmetic_unit_top");
      $finish;
    end
  end

  initial begin
    logic [1:0] act;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    in_accepted = 1'b0;
    out_stall = 1'b0;
    fail_count = 0;
    result_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every action, extremes, zero denominators, divide by zero, overflow.
    add_op(ACT_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
    add_op(ACT_SUB, 32'd1, 31'd2, 32'd1, 31'd2);
    add_op(ACT_MUL, 32'hFFFF_FFFE, 31'd4, 32'd6, 31'd9);
    add_op(ACT_DIV, 32'd3, 31'd5, 32'hFFFF_FFFD, 31'd7);
    add_op(ACT_ADD, 32'd1, 31'd0, 32'd1, 31'd1);
    add_op(ACT_DIV, 32'd1, 31'd1, 32'd5, 31'd0);
    add_op(ACT_DIV, 32'd7, 31'd3, 32'd0, 31'd5);
    add_op(ACT_MUL, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1);
    add_op(ACT_MUL, 32'h8000_0000, 31'd1, 32'hFFFF_FFFF, 31'd1);
    add_op(ACT_SUB, 32'h8000_0000, 31'd1, 32'd0, 31'd1);
    add_op(ACT_ADD, 32'h8000_0000, 31'd1, 32'hFFFF_FFFF, 31'd1);
    add_op(ACT_DIV, 32'd1, 31'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFE);
    add_op(ACT_ADD, 32'd1, 31'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFE);
    add_op(ACT_DIV, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
    add_op(ACT_ADD, 32'd4, 31'd8, 32'd6, 31'd12);
    add_op(ACT_MUL, 32'd0, 31'd3, 32'hFFFF_FFF9, 31'd5);
    add_op(ACT_SUB, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1);
    add_op(ACT_DIV, 32'd0, 31'd0, 32'd0, 31'd0);

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      wait (pending_ops.size() == 0 && expected_results.size() == 0);
      @(negedge clk);
      send_idle_pct = (phase == 1) ? 88 : (phase == 3) ? 14 : 0;
      recv_stall_pct = (phase == 2) ? 88 : (phase == 3) ? 14 : 0;
      for (int i = 0; i < 150; i++) begin
        act = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
          add_op(act, rand_num(), rand_den(), rand_num(), rand_den());
        else if ($urandom_range(0, 5) == 0)
          add_op(act, rand_num(), rand_den(), (act == ACT_DIV) ? 32'd0 : rand_num(),
                 rand_den());
        else
          add_op(act, rand_num(), rand_den() | 31'd1, rand_num(), rand_den() | 31'd1);
      end
    end

    wait (pending_ops.size() == 0 && expected_results.size() == 0 && !in_valid);
    repeat (400) @(posedge clk);
    $display("covered %0d results: ok %0d, div-by-zero %0d, zero-den %0d, overflow %0d",
             result_count, status_seen[ST_OK], status_seen[ST_DIVZ],
             status_seen[ST_DENZ], status_seen[ST_OVF]);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS rational_arithmetic_unit_top");
    end else begin
      $display("FAIL rational_arithmetic_unit_top");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
design/rau_pkg.sv
design/rau_front.sv
design/rau_queue.sv
design/rau_back.sv
design/rational_arithmetic_unit_top.sv
tb/tb_rational_arithmetic_unit_top.sv
